[hw/rtl/ccb_pkg.sv]
// ----------------------------------------------------------------------------
// ccb_pkg: shared definitions for the COO-to-CSR pattern builder
// Field widths, operation and status codes, defaults, memory control groups.
// ----------------------------------------------------------------------------
package ccb_pkg;

  localparam int unsigned DefMaxOrder   = 256;
  localparam int unsigned DefMaxEntries = 4096;

  localparam int unsigned OpW     = 2;
  localparam int unsigned RowW    = 8;
  localparam int unsigned IdxW    = 13;
  localparam int unsigned ValueW  = 13;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OrderW  = 9;

  localparam logic [OpW-1:0] OpInsert  = 2'd0;
  localparam logic [OpW-1:0] OpPack    = 2'd1;
  localparam logic [OpW-1:0] OpReadRow = 2'd2;
  localparam logic [OpW-1:0] OpReadCol = 2'd3;

  localparam logic [StatusW-1:0] StOk     = 2'd0;
  localparam logic [StatusW-1:0] StPacked = 2'd1;
  localparam logic [StatusW-1:0] StRange  = 2'd2;
  localparam logic [StatusW-1:0] StFull   = 2'd3;

  localparam logic CfgOrder = 1'b0;
  localparam logic CfgDiag  = 1'b1;

  localparam logic [OrderW-1:0] OrderReset = 9'd256;

  // write enables of the CSR result memories
  typedef struct packed {
    logic rs_we;
    logic cl_we;
  } csr_wr_t;

endpackage

[hw/rtl/ccb_entry_store.sv]
// ----------------------------------------------------------------------------
// ccb_entry_store: coordinate entry memory
// One (row, column) pair per word, one write and one registered read port.
// ----------------------------------------------------------------------------
module ccb_entry_store #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned DataW = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hw/rtl/ccb_bitmap_store.sv]
// ----------------------------------------------------------------------------
// ccb_bitmap_store: row occupancy bitmap
// One word per row, bit c set when column c is present in that row.
// ----------------------------------------------------------------------------
module ccb_bitmap_store #(
  parameter int unsigned Rows  = 256,
  parameter int unsigned WordW = 256
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [$clog2(Rows)-1:0] waddr_i,
  input  logic [WordW-1:0]        wdata_i,
  input  logic [$clog2(Rows)-1:0] raddr_i,
  output logic [WordW-1:0]        rdata_o
);

  logic [WordW-1:0] mem [Rows];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hw/rtl/ccb_csr_store.sv]
// ----------------------------------------------------------------------------
// ccb_csr_store: packed CSR pattern
// Row start array and packed column list, each with a registered read port.
// ----------------------------------------------------------------------------
module ccb_csr_store
  import ccb_pkg::*;
#(
  parameter int unsigned RsDepth = 257,
  parameter int unsigned ClDepth = 4352,
  parameter int unsigned RsW     = 13,
  parameter int unsigned ClW     = 8
) (
  input  logic                       clk_i,
  input  csr_wr_t                    wr_i,
  input  logic [$clog2(RsDepth)-1:0] rs_waddr_i,
  input  logic [RsW-1:0]             rs_wdata_i,
  input  logic [$clog2(ClDepth)-1:0] cl_waddr_i,
  input  logic [ClW-1:0]             cl_wdata_i,
  input  logic [$clog2(RsDepth)-1:0] rs_raddr_i,
  input  logic [$clog2(ClDepth)-1:0] cl_raddr_i,
  output logic [RsW-1:0]             rs_rdata_o,
  output logic [ClW-1:0]             cl_rdata_o
);

  logic [RsW-1:0] rs_mem [RsDepth];
  logic [ClW-1:0] cl_mem [ClDepth];

  always_ff @(posedge clk_i) begin
    if (wr_i.rs_we) begin
      rs_mem[rs_waddr_i] <= rs_wdata_i;
    end
    rs_rdata_o <= rs_mem[rs_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.cl_we) begin
      cl_mem[cl_waddr_i] <= cl_wdata_i;
    end
    cl_rdata_o <= cl_mem[cl_raddr_i];
  end

endmodule

[hw/rtl/sparse_coo_to_csr_builder_core.sv]
// ----------------------------------------------------------------------------
// sparse_coo_to_csr_builder_core: coordinate to compressed sparse row builder
// Collects (row, column) words, packs them into a sorted, duplicate-free CSR
// pattern and answers row start and column reads.
// ----------------------------------------------------------------------------
// Insert: result strobe on the next cycle, one insert per cycle while idle.
// Reads of a packed pattern: busy while the read is under way, result through
// the registered memory read port and then the output register.
// Pack (explicit or ahead of a first read): clear sweep over the n bitmap rows,
// walk of the E stored words, then a column scan of each row, for order n.
// Reset clears all control state; memories are not cleared. The result
// receiver cannot stall, so a result is shown for exactly one cycle.
module sparse_coo_to_csr_builder_core
  import ccb_pkg::*;
#(
  parameter int unsigned MAX_ORDER   = DefMaxOrder,
  parameter int unsigned MAX_ENTRIES = DefMaxEntries
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               start_i,
  output logic               busy_o,
  input  logic [OpW-1:0]     operation_i,
  input  logic [RowW-1:0]    row_i,
  input  logic [RowW-1:0]    column_i,
  input  logic [IdxW-1:0]    index_i,
  // result channel
  output logic               done_o,
  output logic [StatusW-1:0] status_o,
  output logic [ValueW-1:0]  value_o,
  // configuration channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [OrderW-1:0]  cfg_data_i
);

  localparam int unsigned Pool = MAX_ENTRIES + MAX_ORDER;
  localparam int unsigned RW   = $clog2(MAX_ORDER);       // row / column index
  localparam int unsigned OW   = $clog2(MAX_ORDER + 1);   // order, row start addr
  localparam int unsigned AW   = $clog2(MAX_ENTRIES);     // entry address
  localparam int unsigned EW   = $clog2(MAX_ENTRIES + 1); // entry count
  localparam int unsigned PAW  = $clog2(Pool);            // column list address
  localparam int unsigned PW   = $clog2(Pool + 1);        // nonzero count
  localparam int unsigned CW   = (OW > RowW) ? OW : RowW;
  localparam int unsigned IXW  = (PW > IdxW) ? PW : IdxW;
  localparam int unsigned OCW  = (OW > OrderW) ? OW : OrderW;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_LDE, S_LDB, S_WRB, S_SROW, S_SWAIT, S_SCOL, S_SEND,
    S_RDISS, S_RD
  } state_e;

  state_e state_q;

  // configuration
  logic [OrderW-1:0] order_q;
  logic              diag_q;
  logic [OW-1:0]     n_eff;

  // builder state
  logic [EW-1:0]  cnt_q;
  logic           packed_q;
  logic [OW-1:0]  n_q;       // order latched by the pack
  logic [PW-1:0]  nnz_q;
  logic [PW-1:0]  w_q;       // write pointer into the column list
  logic [EW-1:0]  k_q;       // entry walk
  logic [RW-1:0]  r_q;       // row walk
  logic [RW-1:0]  c_q;       // column scan
  logic [RW-1:0]  er_q;
  logic [RW-1:0]  ec_q;
  logic [MAX_ORDER-1:0] word_q;
  logic [OpW-1:0] op_q;
  logic [IdxW-1:0] idx_q;

  // result register
  logic               done_q;
  logic [StatusW-1:0] status_q;
  logic [ValueW-1:0]  value_q;

  // memory ports
  logic                 ent_we;
  logic [2*RowW-1:0]    ent_rdata;
  logic                 bm_we;
  logic [RW-1:0]        bm_waddr;
  logic [MAX_ORDER-1:0] bm_wdata;
  logic [RW-1:0]        bm_raddr;
  logic [MAX_ORDER-1:0] bm_rdata;
  csr_wr_t              csr_wr;
  logic [OW-1:0]        rs_waddr;
  logic [IdxW-1:0]      rd_idx;
  logic [PW-1:0]        rs_rdata;
  logic [RW-1:0]        cl_rdata;

  logic accept;
  logic ins_ok;
  logic [RW-1:0] ent_row;
  logic [RW-1:0] ent_col;
  logic ent_in;
  logic last_col;
  logic last_row;

  assign busy_o      = (state_q != S_IDLE);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign value_o     = value_q;

  // order 0 acts as 1, anything above the limit as the limit
  always_comb begin
    if (order_q == '0) begin
      n_eff = OW'(1);
    end else if (OCW'(order_q) > OCW'(MAX_ORDER)) begin
      n_eff = OW'(MAX_ORDER);
    end else begin
      n_eff = OW'(order_q);
    end
  end

  assign ins_ok = (CW'(row_i) < CW'(n_eff)) && (CW'(column_i) < CW'(n_eff));

  assign ent_row  = RW'(ent_rdata[2*RowW-1:RowW]);
  assign ent_col  = RW'(ent_rdata[RowW-1:0]);
  assign ent_in   = (CW'(ent_rdata[2*RowW-1:RowW]) < CW'(n_q)) &&
                    (CW'(ent_rdata[RowW-1:0]) < CW'(n_q));
  assign last_col = ((OW'(c_q) + OW'(1)) == n_q);
  assign last_row = ((OW'(r_q) + OW'(1)) == n_q);

  assign ent_we = accept && (operation_i == OpInsert) && !packed_q && ins_ok &&
                  (cnt_q < EW'(MAX_ENTRIES));

  // bitmap: reset rows (or set diagonal) in clear sweep, set bits in entry walk
  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = r_q;
    bm_wdata = '0;
    bm_raddr = r_q;
    unique case (state_q)
      S_CLR: begin
        bm_we    = 1'b1;
        bm_wdata = diag_q ? (MAX_ORDER'(1) << r_q) : '0;
      end
      S_LDB: begin
        bm_raddr = ent_row;
      end
      S_WRB: begin
        bm_we    = 1'b1;
        bm_waddr = er_q;
        bm_wdata = bm_rdata | (MAX_ORDER'(1) << ec_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    csr_wr.rs_we = (state_q == S_SWAIT) || (state_q == S_SEND);
    csr_wr.cl_we = (state_q == S_SCOL) && word_q[c_q];
    rs_waddr     = (state_q == S_SEND) ? n_q : OW'(r_q);
  end

  assign rd_idx = (state_q == S_IDLE) ? index_i : idx_q;

  ccb_entry_store #(
    .Depth (MAX_ENTRIES),
    .DataW (2*RowW)
  ) u_entry (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (AW'(cnt_q)),
    .wdata_i ({row_i, column_i}),
    .raddr_i (AW'(k_q)),
    .rdata_o (ent_rdata)
  );

  ccb_bitmap_store #(
    .Rows  (MAX_ORDER),
    .WordW (MAX_ORDER)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  ccb_csr_store #(
    .RsDepth (MAX_ORDER + 1),
    .ClDepth (Pool),
    .RsW     (PW),
    .ClW     (RW)
  ) u_csr (
    .clk_i      (clk_i),
    .wr_i       (csr_wr),
    .rs_waddr_i (rs_waddr),
    .rs_wdata_i (w_q),
    .cl_waddr_i (PAW'(w_q)),
    .cl_wdata_i (c_q),
    .rs_raddr_i (OW'(rd_idx)),
    .cl_raddr_i (PAW'(rd_idx)),
    .rs_rdata_o (rs_rdata),
    .cl_rdata_o (cl_rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= OrderReset;
      diag_q  <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgOrder: order_q <= cfg_data_i;
        CfgDiag:  diag_q  <= cfg_data_i[0];
        default:  ;
      endcase
    end
  end

  // sequencer: command decode, pack sweeps, reads, result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      packed_q <= 1'b0;
      n_q      <= '0;
      nnz_q    <= '0;
      w_q      <= '0;
      k_q      <= '0;
      r_q      <= '0;
      c_q      <= '0;
      done_q   <= 1'b0;
      status_q <= StOk;
      value_q  <= '0;
      op_q     <= OpInsert;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q  <= operation_i;
            idx_q <= index_i;
            unique case (operation_i)
              OpInsert: begin
                done_q  <= 1'b1;
                value_q <= '0;
                if (packed_q) begin
                  status_q <= StPacked;
                end else if (!ins_ok) begin
                  status_q <= StRange;
                end else if (cnt_q >= EW'(MAX_ENTRIES)) begin
                  status_q <= StFull;
                end else begin
                  status_q <= StOk;
                  cnt_q    <= cnt_q + EW'(1);
                end
              end
              OpPack: begin
                if (packed_q) begin
                  done_q   <= 1'b1;
                  status_q <= StPacked;
                  value_q  <= ValueW'(nnz_q);
                end else begin
                  n_q     <= n_eff;
                  r_q     <= '0;
                  state_q <= S_CLR;
                end
              end
              default: begin
                if (packed_q) begin
                  state_q <= S_RD;
                end else begin
                  n_q     <= n_eff;
                  r_q     <= '0;
                  state_q <= S_CLR;
                end
              end
            endcase
          end
        end
        S_CLR: begin
          k_q <= '0;
          if (last_row) begin
            r_q     <= '0;
            state_q <= (cnt_q == '0) ? S_SROW : S_LDE;
          end else begin
            r_q <= r_q + RW'(1);
          end
        end
        S_LDE: state_q <= S_LDB;
        S_LDB: begin
          er_q <= ent_row;
          ec_q <= ent_col;
          if (ent_in) begin
            state_q <= S_WRB;
          end else if (k_q + EW'(1) == cnt_q) begin
            state_q <= S_SROW;
          end else begin
            k_q     <= k_q + EW'(1);
            state_q <= S_LDE;
          end
        end
        S_WRB: begin
          if (k_q + EW'(1) == cnt_q) begin
            state_q <= S_SROW;
          end else begin
            k_q     <= k_q + EW'(1);
            state_q <= S_LDE;
          end
        end
        S_SROW: state_q <= S_SWAIT;
        S_SWAIT: begin
          word_q  <= bm_rdata;
          c_q     <= '0;
          state_q <= S_SCOL;
        end
        S_SCOL: begin
          if (word_q[c_q]) begin
            w_q <= w_q + PW'(1);
          end
          c_q <= c_q + RW'(1);
          if (last_col) begin
            if (last_row) begin
              state_q <= S_SEND;
            end else begin
              r_q     <= r_q + RW'(1);
              state_q <= S_SROW;
            end
          end
        end
        S_SEND: begin
          packed_q <= 1'b1;
          nnz_q    <= w_q;
          if (op_q == OpPack) begin
            done_q   <= 1'b1;
            status_q <= StOk;
            value_q  <= ValueW'(w_q);
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_RDISS;
          end
        end
        S_RDISS: state_q <= S_RD;
        S_RD: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
          if (op_q == OpReadRow) begin
            if (IXW'(idx_q) > IXW'(n_q)) begin
              status_q <= StRange;
              value_q  <= '0;
            end else begin
              status_q <= StOk;
              value_q  <= ValueW'(rs_rdata);
            end
          end else begin
            if (IXW'(idx_q) >= IXW'(nnz_q)) begin
              status_q <= StRange;
              value_q  <= '0;
            end else begin
              status_q <= StOk;
              value_q  <= ValueW'(cl_rdata);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a result never appears while a command is still in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("result strobe while busy");

  // the entry count never passes the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= EW'(MAX_ENTRIES))
    else $error("entry count overflow");

  // once packed, the pattern stays packed until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni) packed_q |=> packed_q)
    else $error("packed flag dropped");

  // nothing is stored after packing
  assert property (@(posedge clk_i) disable iff (!rst_ni) packed_q |-> !ent_we)
    else $error("entry write after pack");
`endif

endmodule
